// ===== rtl/ccvs_pkg.sv =====
`timescale 1ns / 1ps
package ccvs_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int STRAIN_W = 32;
  localparam int FRAC_W = 16;
  localparam int RHO_W = 20;
  localparam int EDDY_W = 24;
  localparam int NB_W = FRAC_W + RHO_W + EDDY_W;
  localparam int MU_W = 24;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 24;
  localparam int QUEUE_DEPTH = 4;

  // Sum of four fractions, and the sum that counts as four full cells.
  localparam int FSUM_W = FRAC_W + 2;
  localparam logic [FSUM_W-1:0] FULL_SUM = 18'd131072;

  // Pipelined divider for the volume-weighted averages.
  localparam int DIV_QW = EDDY_W;
  localparam int DIV_DW = FSUM_W;
  localparam int DIV_NW = DIV_QW + DIV_DW;

  typedef enum logic [1:0] {
    FUNC_CENTRE = 2'd0,
    FUNC_XY     = 2'd1,
    FUNC_XZ     = 2'd2,
    FUNC_YZ     = 2'd3
  } func_t;

  localparam logic [CFG_IDX_W-1:0] CFG_MU    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DENS  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TURB  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER = 4'd3;

  typedef struct packed {
    logic [MU_W-1:0] mu;
    logic            dens;
    logic            turb;
    logic [2:0]      inner;
  } cfg_t;

  // One queued transaction with its classification.
  typedef struct packed {
    logic                       centre;
    logic                       zc;
    logic                       b_on;
    logic                       i_on;
    logic signed [STRAIN_W-1:0] sa;
    logic signed [STRAIN_W-1:0] sb;
    logic signed [STRAIN_W-1:0] sc;
    logic signed [STRAIN_W-1:0] er;
    logic [NB_W-1:0]            na;
    logic [NB_W-1:0]            nb;
    logic [NB_W-1:0]            nc;
    logic [NB_W-1:0]            nd;
  } item_t;

  function automatic logic [FRAC_W-1:0] nb_frac(input logic [NB_W-1:0] n);
    return n[FRAC_W-1:0];
  endfunction

  function automatic logic [RHO_W-1:0] nb_rho(input logic [NB_W-1:0] n);
    return n[FRAC_W+RHO_W-1:FRAC_W];
  endfunction

  function automatic logic [EDDY_W-1:0] nb_eddy(input logic [NB_W-1:0] n);
    return n[NB_W-1:FRAC_W+RHO_W];
  endfunction

endpackage

// ===== rtl/ccvs_div.sv =====
`timescale 1ns / 1ps
module ccvs_div import ccvs_pkg::*; #(
  parameter int NW = DIV_NW,
  parameter int DW = DIV_DW,
  parameter int QW = DIV_QW
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  // Restoring division, one quotient bit per stage. The quotient must fit in
  // QW bits, which holds because an average never exceeds its largest value.
  logic [DW-1:0] rem_s [QW];
  logic [QW-1:0] low_s [QW];
  logic [DW-1:0] den_s [QW];
  logic [QW-1:0] q_s   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [QW-1:0] low_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] q_in;
    logic [DW:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = DW'(num >> QW);
      assign low_in = num[QW-1:0];
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_s[k-1];
      assign low_in = low_s[k-1];
      assign den_in = den_s[k-1];
      assign q_in   = q_s[k-1];
    end

    assign trial = {rem_in, low_in[QW-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k] <= ge ? DW'(trial - {1'b0, den_in}) : DW'(trial);
        low_s[k] <= low_in << 1;
        den_s[k] <= den_in;
        q_s[k]   <= {q_in[QW-2:0], ge};
      end
    end
  end

  assign quo = q_s[QW-1];

endmodule

// ===== rtl/ccvs_front.sv =====
`timescale 1ns / 1ps
module ccvs_front import ccvs_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cfg_t                       cfg,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 func,
  input  logic signed [STRAIN_W-1:0] strain_a,
  input  logic signed [STRAIN_W-1:0] strain_b,
  input  logic signed [STRAIN_W-1:0] strain_c,
  input  logic signed [STRAIN_W-1:0] expansion_rate,
  input  logic [NB_W-1:0]            neighbor_a,
  input  logic [NB_W-1:0]            neighbor_b,
  input  logic [NB_W-1:0]            neighbor_c,
  input  logic [NB_W-1:0]            neighbor_d,
  input  logic                       pop,
  output logic                       head_valid,
  output item_t                      head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            queue [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  item_t            item;

  always_comb begin
    item = '0;
    item.sa = strain_a;
    item.sb = strain_b;
    item.sc = strain_c;
    item.er = expansion_rate;
    item.na = neighbor_a;
    item.nb = neighbor_b;
    item.nc = neighbor_c;
    item.nd = neighbor_d;
    unique case (func_t'(func))
      FUNC_CENTRE: begin
        item.centre = 1'b1;
        item.zc     = nb_frac(neighbor_a) == '0;
        item.b_on   = 1'b1;
        item.i_on   = cfg.inner[2];
      end
      FUNC_XY: begin
        item.b_on = 1'b0;
      end
      FUNC_XZ: begin
        item.b_on = cfg.inner[0];
      end
      FUNC_YZ: begin
        item.b_on = cfg.inner[1];
      end
      default: begin
        item.b_on = 1'b0;
      end
    endcase
  end

  assign in_stall   = count == CNT_W'(DEPTH);
  assign push       = in_valid && !in_stall;
  assign head_valid = count != '0;
  assign head       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

// ===== rtl/ccvs_back.sv =====
`timescale 1ns / 1ps
module ccvs_back import ccvs_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cfg_t                          cfg,
  input  logic                          head_valid,
  input  item_t                         head,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [VALUE_WIDTH-1:0] stress_a,
  output logic signed [VALUE_WIDTH-1:0] stress_b,
  output logic signed [VALUE_WIDTH-1:0] stress_c,
  output logic signed [VALUE_WIDTH-1:0] stress_inner,
  output logic                          saturated
);

  localparam int XW     = STRAIN_W + 2;
  localparam int RSUM_W = RHO_W + 2;
  localparam int ESUM_W = EDDY_W + 2;
  localparam int FR_W   = FRAC_W + RHO_W;
  localparam int FE_W   = FRAC_W + EDDY_W;
  localparam int MP_W   = RHO_W + MU_W;
  localparam int M_W    = MP_W - 16;
  localparam int MH_W   = M_W + 1;
  localparam int PROD_W = MH_W + 1 + XW;
  localparam int NEG_W  = PROD_W + 2;
  localparam int LANE_W = NEG_W - 16;
  localparam int LO_W   = 24;
  localparam int HI_W   = LANE_W - LO_W;
  localparam int S_W    = HI_W + 1;
  localparam int U_W    = S_W + 1;
  localparam int G_W    = U_W + 32 - 33;

  localparam logic signed [NEG_W-1:0] BIAS1 = NEG_W'(32768);
  localparam logic signed [NEG_W-1:0] BIAS3 = NEG_W'(98304);
  // 2^24 = 3 * THIRD_HI + 1, so x/3 splits into a high and a low part.
  localparam logic [LO_W-1:0] THIRD_HI = 24'd5592405;
  localparam logic [31:0]     RECIP3   = 32'hAAAAAAAB;
  localparam logic [U_W-1:0]  S_OFFSET = U_W'(3 * (2 ** (S_W - 1)));
  localparam logic signed [LANE_W-1:0] G_OFFSET = LANE_W'(2 ** (S_W - 1));
  localparam logic signed [LANE_W-1:0] SAT_HI =
    {{(LANE_W - VALUE_WIDTH + 1){1'b0}}, {(VALUE_WIDTH - 1){1'b1}}};
  localparam logic signed [LANE_W-1:0] SAT_LO =
    {{(LANE_W - VALUE_WIDTH + 1){1'b1}}, {(VALUE_WIDTH - 1){1'b0}}};

  typedef struct packed {
    logic                       v;
    logic                       centre;
    logic                       zc;
    logic                       b_on;
    logic                       i_on;
    logic                       use_avg;
    logic                       nz;
    logic [RHO_W-1:0]           avg_r;
    logic [EDDY_W-1:0]          avg_e;
    logic [EDDY_W-1:0]          ev;
    logic signed [XW-1:0]       x0;
    logic signed [XW-1:0]       x1;
    logic signed [XW-1:0]       x2;
    logic signed [STRAIN_W-1:0] x3;
  } side_t;

  function automatic logic signed [XW-1:0] tri_diff(
    input logic signed [STRAIN_W-1:0] s,
    input logic signed [STRAIN_W-1:0] e
  );
    return XW'(s) + XW'(s) + XW'(s) - XW'(e);
  endfunction

  logic adv;
  assign adv = !(out_valid && out_stall);
  assign pop = adv && head_valid;

  // Stage 1: neighbor products, fraction sums and strain combinations.
  logic [NB_W-1:0]   nbr [4];
  side_t             sd1_next, sd1;
  logic [FR_W-1:0]   pr1 [4];
  logic [FE_W-1:0]   pe1 [4];
  logic [FSUM_W-1:0] vs1;
  logic [RSUM_W-1:0] rsum1;
  logic [ESUM_W-1:0] esum1;

  assign nbr[0] = head.na;
  assign nbr[1] = head.nb;
  assign nbr[2] = head.nc;
  assign nbr[3] = head.nd;

  always_comb begin
    sd1_next = '0;
    sd1_next.v      = head_valid;
    sd1_next.centre = head.centre;
    sd1_next.zc     = head.zc;
    sd1_next.b_on   = head.b_on;
    sd1_next.i_on   = head.i_on;
    sd1_next.x3     = head.sc;
    if (head.centre) begin
      sd1_next.use_avg = 1'b1;
      sd1_next.avg_r   = nb_rho(head.na);
      sd1_next.avg_e   = nb_eddy(head.na);
      sd1_next.ev      = nb_eddy(head.nb);
      sd1_next.x0      = tri_diff(head.sa, head.er);
      sd1_next.x1      = tri_diff(head.sb, head.er);
      sd1_next.x2      = tri_diff(head.sc, head.er);
    end else begin
      sd1_next.x0 = XW'(head.sa);
      sd1_next.x1 = XW'(head.sb);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sd1.v <= 1'b0;
    end else if (adv) begin
      sd1   <= sd1_next;
      vs1   <= FSUM_W'(nb_frac(nbr[0])) + FSUM_W'(nb_frac(nbr[1]))
             + FSUM_W'(nb_frac(nbr[2])) + FSUM_W'(nb_frac(nbr[3]));
      rsum1 <= RSUM_W'(nb_rho(nbr[0])) + RSUM_W'(nb_rho(nbr[1]))
             + RSUM_W'(nb_rho(nbr[2])) + RSUM_W'(nb_rho(nbr[3]));
      esum1 <= ESUM_W'(nb_eddy(nbr[0])) + ESUM_W'(nb_eddy(nbr[1]))
             + ESUM_W'(nb_eddy(nbr[2])) + ESUM_W'(nb_eddy(nbr[3]));
      for (int i = 0; i < 4; i++) begin
        pr1[i] <= FR_W'(nb_frac(nbr[i])) * FR_W'(nb_rho(nbr[i]));
        pe1[i] <= FE_W'(nb_frac(nbr[i])) * FE_W'(nb_eddy(nbr[i]));
      end
    end
  end

  // Stage 2: weighted sums with the rounding half added, and plain averages.
  side_t             sd2_next, sd2;
  logic [DIV_NW-1:0] nr2, ne2;
  logic [FSUM_W-1:0] vs2;

  always_comb begin
    sd2_next = sd1;
    if (!sd1.centre) begin
      sd2_next.use_avg = vs1 >= FULL_SUM;
      sd2_next.nz      = vs1 != '0;
      sd2_next.avg_r   = RHO_W'((rsum1 + RSUM_W'(2)) >> 2);
      sd2_next.avg_e   = EDDY_W'((esum1 + ESUM_W'(2)) >> 2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sd2.v <= 1'b0;
    end else if (adv) begin
      sd2 <= sd2_next;
      vs2 <= vs1;
      nr2 <= DIV_NW'(pr1[0]) + DIV_NW'(pr1[1]) + DIV_NW'(pr1[2]) + DIV_NW'(pr1[3])
           + DIV_NW'(vs1 >> 1);
      ne2 <= DIV_NW'(pe1[0]) + DIV_NW'(pe1[1]) + DIV_NW'(pe1[2]) + DIV_NW'(pe1[3])
           + DIV_NW'(vs1 >> 1);
    end
  end

  // Divider stages, with the side data delayed alongside.
  logic [DIV_QW-1:0] qr, qe;
  side_t             sdd [DIV_QW];

  ccvs_div #(.NW(DIV_NW), .DW(DIV_DW), .QW(DIV_QW)) u_div_rho (
    .clk (clk),
    .en  (adv),
    .num (nr2),
    .den (vs2),
    .quo (qr)
  );

  ccvs_div #(.NW(DIV_NW), .DW(DIV_DW), .QW(DIV_QW)) u_div_eddy (
    .clk (clk),
    .en  (adv),
    .num (ne2),
    .den (vs2),
    .quo (qe)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_QW; k++) begin
        sdd[k].v <= 1'b0;
      end
    end else if (adv) begin
      sdd[0] <= sd2;
      for (int k = 1; k < DIV_QW; k++) begin
        sdd[k] <= sdd[k-1];
      end
    end
  end

  // Stage 3: pick the averages and scale density by the molecular term.
  side_t             sd3;
  logic [RHO_W-1:0]  rsel;
  logic [EDDY_W-1:0] esel, esel3;
  logic [MP_W-1:0]   mprod3;

  always_comb begin
    if (sdd[DIV_QW-1].use_avg) begin
      rsel = sdd[DIV_QW-1].avg_r;
      esel = sdd[DIV_QW-1].avg_e;
    end else if (sdd[DIV_QW-1].nz) begin
      rsel = qr[RHO_W-1:0];
      esel = qe;
    end else begin
      rsel = '0;
      esel = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sd3.v <= 1'b0;
    end else if (adv) begin
      sd3    <= sdd[DIV_QW-1];
      esel3  <= esel;
      mprod3 <= MP_W'(rsel) * MP_W'(cfg.mu);
    end
  end

  // Stage 4: horizontal and vertical viscosities.
  side_t           sd4;
  logic [M_W-1:0]  mol;
  logic [MH_W-1:0] mh4, mv4;

  always_comb begin
    if (cfg.dens) begin
      mol = M_W'(({1'b0, mprod3} + (MP_W + 1)'(32768)) >> 16);
    end else begin
      mol = M_W'(cfg.mu);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sd4.v <= 1'b0;
    end else if (adv) begin
      sd4 <= sd3;
      mh4 <= MH_W'(mol) + (cfg.turb ? MH_W'({esel3, 1'b0}) : '0);
      mv4 <= MH_W'(mol) + (cfg.turb ? MH_W'({sd3.ev, 1'b0}) : '0);
    end
  end

  // Stage 5: viscosity times strain, one multiplier per result.
  side_t                    sd5;
  logic signed [MH_W:0]     mh_s, mv_s;
  logic signed [PROD_W-1:0] p5 [4];

  assign mh_s = $signed({1'b0, mh4});
  assign mv_s = $signed({1'b0, mv4});

  always_ff @(posedge clk) begin
    if (rst) begin
      sd5.v <= 1'b0;
    end else if (adv) begin
      sd5   <= sd4;
      p5[0] <= mh_s * sd4.x0;
      p5[1] <= mh_s * sd4.x1;
      p5[2] <= mv_s * sd4.x2;
      p5[3] <= mv_s * sd4.x3;
    end
  end

  // Stage 6: negate, round and drop results that this transaction does not have.
  logic                     v6;
  logic signed [LANE_W-1:0] lane6 [4];
  logic                     d6    [4];
  logic                     keep  [4];
  logic                     div3  [4];
  logic signed [NEG_W-1:0]  t6    [4];

  always_comb begin
    keep[0] = !sd5.zc;
    keep[1] = sd5.b_on && !sd5.zc;
    keep[2] = sd5.centre && !sd5.zc;
    keep[3] = sd5.i_on && !sd5.zc;
    for (int l = 0; l < 4; l++) begin
      div3[l] = sd5.centre && (l < 3);
      t6[l]   = -NEG_W'(p5[l]) + (div3[l] ? BIAS3 : BIAS1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (adv) begin
      v6 <= sd5.v;
      for (int l = 0; l < 4; l++) begin
        lane6[l] <= keep[l] ? t6[l][NEG_W-1:16] : '0;
        d6[l]    <= div3[l];
      end
    end
  end

  // Stages 7 to 9: exact floor division by three on the lanes that need it, then saturation.
  logic                     v7, v8;
  logic signed [LANE_W-1:0] m7 [4];
  logic signed [S_W-1:0]    s7 [4];
  logic signed [LANE_W-1:0] m8 [4];
  logic [G_W-1:0]           g8 [4];
  logic signed [HI_W-1:0]   hi [4];
  logic [U_W-1:0]           u8 [4];
  logic [U_W+31:0]          up [4];
  logic signed [LANE_W-1:0] q9 [4];
  logic                     hi_clip [4];
  logic                     lo_clip [4];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      hi[l]      = lane6[l][LANE_W-1:LO_W];
      u8[l]      = U_W'(s7[l]) + S_OFFSET;
      up[l]      = (U_W + 32)'(u8[l]) * (U_W + 32)'(RECIP3);
      q9[l]      = m8[l] + $signed(LANE_W'(g8[l])) - G_OFFSET;
      hi_clip[l] = q9[l] > SAT_HI;
      lo_clip[l] = q9[l] < SAT_LO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else if (adv) begin
      v7 <= v6;
      v8 <= v7;
      for (int l = 0; l < 4; l++) begin
        if (d6[l]) begin
          m7[l] <= hi[l] * $signed({1'b0, THIRD_HI});
          s7[l] <= S_W'(hi[l]) + $signed(S_W'(lane6[l][LO_W-1:0]));
        end else begin
          m7[l] <= lane6[l];
          s7[l] <= '0;
        end
        m8[l] <= m7[l];
        g8[l] <= up[l][U_W+31:33];
      end
    end
  end

  logic signed [VALUE_WIDTH-1:0] res [4];
  logic                          any_clip;

  always_comb begin
    any_clip = 1'b0;
    for (int l = 0; l < 4; l++) begin
      if (hi_clip[l]) begin
        res[l] = SAT_HI[VALUE_WIDTH-1:0];
      end else if (lo_clip[l]) begin
        res[l] = SAT_LO[VALUE_WIDTH-1:0];
      end else begin
        res[l] = q9[l][VALUE_WIDTH-1:0];
      end
      any_clip = any_clip | hi_clip[l] | lo_clip[l];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid    <= v8;
      stress_a     <= res[0];
      stress_b     <= res[1];
      stress_c     <= res[2];
      stress_inner <= res[3];
      saturated    <= any_clip;
    end
  end

endmodule

// ===== rtl/cut_cell_viscous_stress.sv =====
`timescale 1ns / 1ps
// One transaction per cycle unless stalled; the back end is fully pipelined,
// including two 24-stage restoring dividers that form the volume-weighted averages.
// A stall on the output freezes the whole back end; a 4-entry queue absorbs input.
// Reset clears the configuration registers to zero and empties queue and pipeline.
module cut_cell_viscous_stress import ccvs_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    func,
  input  logic signed [STRAIN_W-1:0]    strain_a,
  input  logic signed [STRAIN_W-1:0]    strain_b,
  input  logic signed [STRAIN_W-1:0]    strain_c,
  input  logic signed [STRAIN_W-1:0]    expansion_rate,
  input  logic [NB_W-1:0]               neighbor_a,
  input  logic [NB_W-1:0]               neighbor_b,
  input  logic [NB_W-1:0]               neighbor_c,
  input  logic [NB_W-1:0]               neighbor_d,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [VALUE_WIDTH-1:0] stress_a,
  output logic signed [VALUE_WIDTH-1:0] stress_b,
  output logic signed [VALUE_WIDTH-1:0] stress_c,
  output logic signed [VALUE_WIDTH-1:0] stress_inner,
  output logic                          saturated
);

  cfg_t  cfg;
  item_t head;
  logic  head_valid;
  logic  pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MU:    cfg.mu    <= cfg_data[MU_W-1:0];
        CFG_DENS:  cfg.dens  <= cfg_data[0];
        CFG_TURB:  cfg.turb  <= cfg_data[0];
        CFG_INNER: cfg.inner <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  ccvs_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .func           (func),
    .strain_a       (strain_a),
    .strain_b       (strain_b),
    .strain_c       (strain_c),
    .expansion_rate (expansion_rate),
    .neighbor_a     (neighbor_a),
    .neighbor_b     (neighbor_b),
    .neighbor_c     (neighbor_c),
    .neighbor_d     (neighbor_d),
    .pop            (pop),
    .head_valid     (head_valid),
    .head           (head)
  );

  ccvs_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .stress_a     (stress_a),
    .stress_b     (stress_b),
    .stress_c     (stress_c),
    .stress_inner (stress_inner),
    .saturated    (saturated)
  );

endmodule
